>>> hdl/modular_exponentiation_assert.svh
// assertion macros for the modular exponentiation checker
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication, off while reset is low
`define MEXP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular exponentiation check failed");

// next-cycle implication, off while reset is low
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular exponentiation check failed");

`endif

>>> hdl/mexp_pkg.sv
// shared widths, operation codes and control structs for modular exponentiation
package mexp_pkg;

    // field widths of the channels
    localparam int DATA_BITS = 32;
    localparam int EXP_BITS  = 63;

    // remainder bits retired per reduction cycle
    localparam int RADIX_BITS = 4;

    // which modular product the shared unit forms
    localparam logic [1:0] OP_BASE = 2'd0;  // base mod m
    localparam logic [1:0] OP_ACC  = 2'd1;  // acc * sq mod m
    localparam logic [1:0] OP_SQR  = 2'd2;  // sq * sq mod m

    typedef struct packed {
        logic       load;
        logic       mul_go;
        logic       red_step;
        logic       wr_acc;
        logic       wr_sq;
        logic       exp_shift;
        logic       res_load;
        logic [1:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic exp_more;
        logic red_last;
        logic mod_zero;
    } t_dp_sts;

endpackage

>>> hdl/mexp_if.sv
// request and response channel interfaces

// request word: base, exponent, modulus
interface mexp_req_if;
    import mexp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] base;
    logic [EXP_BITS-1:0]  exponent;
    logic [DATA_BITS-1:0] modulus;

    modport source (output valid, output base, output exponent, output modulus,
                    input ready);
    modport sink   (input valid, input base, input exponent, input modulus,
                    output ready);
endinterface

// response word: power_mod, bad_modulus
interface mexp_rsp_if;
    import mexp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] power_mod;
    logic                 bad_modulus;

    modport source (output valid, output power_mod, output bad_modulus, input ready);
    modport sink   (input valid, input power_mod, input bad_modulus, output ready);
endinterface

>>> hdl/mexp_datapath.sv
// operand registers, multiplier and radix-16 restoring reduction unit
module mexp_datapath #(
    parameter int OPERAND_BITS = 32
) (
    input  logic                             i_clk,
    input  mexp_pkg::t_dp_cmd                i_cmd,
    input  logic [mexp_pkg::DATA_BITS-1:0]   i_base,
    input  logic [mexp_pkg::EXP_BITS-1:0]    i_exponent,
    input  logic [mexp_pkg::DATA_BITS-1:0]   i_modulus,
    output mexp_pkg::t_dp_sts                o_sts,
    output logic [mexp_pkg::DATA_BITS-1:0]   o_power_mod,
    output logic                             o_bad_modulus
);
    import mexp_pkg::*;

    localparam int N     = OPERAND_BITS;
    localparam int STEPS = (2 * N + RADIX_BITS - 1) / RADIX_BITS;
    localparam int PW    = STEPS * RADIX_BITS;
    localparam int CW    = $clog2(STEPS);

    logic [N-1:0]         r_mod;
    logic [N-1:0]         r_acc;
    logic [N-1:0]         r_sq;
    logic [EXP_BITS-1:0]  r_exp;
    logic                 r_bad;
    logic [PW-1:0]        r_prod;
    logic [N-1:0]         r_rem;
    logic [CW-1:0]        r_cnt;
    logic [DATA_BITS-1:0] r_pm;
    logic                 r_bad_out;

    logic [N-1:0]   w_opa;
    logic [N-1:0]   w_opb;
    logic [2*N-1:0] w_prod;
    logic [N-1:0]   n_rem;
    logic [N-1:0]   w_mod_in;

    assign w_mod_in = i_modulus[N-1:0];

    // multiplier operand select
    always_comb begin
        unique case (i_cmd.op)
            OP_BASE: begin
                w_opa = r_sq;
                w_opb = N'(1);
            end
            OP_ACC: begin
                w_opa = r_acc;
                w_opb = r_sq;
            end
            OP_SQR: begin
                w_opa = r_sq;
                w_opb = r_sq;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_prod = w_opa * w_opb;

    // four restoring steps, top product bits shift into the remainder
    always_comb begin
        logic [N:0]   t;
        logic [N-1:0] rv;
        rv = r_rem;
        for (int k = 0; k < RADIX_BITS; k++) begin
            t = {rv, r_prod[PW-1-k]};
            if (t >= {1'b0, r_mod}) begin
                t = t - {1'b0, r_mod};
            end
            rv = t[N-1:0];
        end
        n_rem = rv;
    end

    // operand and exponent registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mod <= w_mod_in;
            r_sq  <= i_base[N-1:0];
            r_exp <= i_exponent;
            r_bad <= (w_mod_in == '0);
            r_acc <= (w_mod_in == N'(1)) ? '0 : N'(1);
        end else begin
            if (i_cmd.wr_acc) begin
                r_acc <= r_rem;
            end
            if (i_cmd.wr_sq) begin
                r_sq <= r_rem;
            end
            if (i_cmd.exp_shift) begin
                r_exp <= r_exp >> 1;
            end
        end
    end

    // product register and reduction unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_prod <= PW'(w_prod);
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.red_step) begin
            r_prod <= r_prod << RADIX_BITS;
            r_rem  <= n_rem;
            r_cnt  <= r_cnt + CW'(1);
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_pm      <= r_bad ? '0 : DATA_BITS'(r_acc);
            r_bad_out <= r_bad;
        end
    end

    assign o_sts.exp_zero = (r_exp == '0);
    assign o_sts.exp_lsb  = r_exp[0];
    assign o_sts.exp_more = |r_exp[EXP_BITS-1:1];
    assign o_sts.red_last = (r_cnt == CW'(STEPS - 1));
    assign o_sts.mod_zero = r_bad;

    assign o_power_mod   = r_pm;
    assign o_bad_modulus = r_bad_out;

endmodule

>>> hdl/mexp_ctrl.sv
// sequencer for square-and-multiply over the exponent bits
module mexp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mexp_pkg::t_dp_sts i_sts,
    output mexp_pkg::t_dp_cmd o_cmd
);
    import mexp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_RED  = 3'd3;
    localparam logic [2:0] ST_WB   = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_op, n_op;
    logic       r_sq_phase, n_sq_phase;
    logic       r_out_valid, n_out_valid;

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sq_phase  = r_sq_phase;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.op    = r_op;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = OP_BASE;
                    n_sq_phase = 1'b0;
                    n_state    = ST_MUL;
                end
            end
            ST_DEC: begin
                priority if (i_sts.mod_zero || i_sts.exp_zero) begin
                    n_state = ST_FIN;
                end else if (!r_sq_phase && i_sts.exp_lsb) begin
                    n_op    = OP_ACC;
                    n_state = ST_MUL;
                end else if (i_sts.exp_more) begin
                    n_op    = OP_SQR;
                    n_state = ST_MUL;
                end else begin
                    // last set bit done, the final square is never used
                    o_cmd.exp_shift = 1'b1;
                    n_sq_phase      = 1'b0;
                end
            end
            ST_MUL: begin
                o_cmd.mul_go = 1'b1;
                n_state      = ST_RED;
            end
            ST_RED: begin
                o_cmd.red_step = 1'b1;
                if (i_sts.red_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                o_cmd.wr_acc = (r_op == OP_ACC);
                o_cmd.wr_sq  = (r_op != OP_ACC);
                if (r_op == OP_ACC) begin
                    n_sq_phase = 1'b1;
                end
                if (r_op == OP_SQR) begin
                    o_cmd.exp_shift = 1'b1;
                    n_sq_phase      = 1'b0;
                end
                n_state = ST_DEC;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_BASE;
            r_sq_phase  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_sq_phase  <= n_sq_phase;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/modular_exponentiation.sv
// modular exponentiation top level: base ** exponent mod modulus
//
// A request word (base, exponent, modulus) enters on i_req, one result word
// (power_mod, bad_modulus) leaves on o_rsp; both use valid/ready handshakes.
// Only the low OPERAND_BITS bits of base and modulus take part.
// A zero modulus gives bad_modulus = 1 and power_mod = 0.
// One request is worked at a time; i_req.ready is high only while idle.
// Each modular product is reduced by the single shared reduction unit,
// which retires four remainder bits per cycle.
// Exponent zero or a zero modulus still runs the base reduction.
// The result sits in an output register, so a new request is taken while
// the last result waits; a stalled receiver only holds the next result at
// its final step until the register frees.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_rsp.valid; no stored state needs clearing.
module modular_exponentiation #(
    parameter int OPERAND_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mexp_req_if.sink   i_req,
    mexp_rsp_if.source o_rsp
);
    import mexp_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencer
    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // arithmetic
    mexp_datapath #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .i_base        (i_req.base),
        .i_exponent    (i_req.exponent),
        .i_modulus     (i_req.modulus),
        .o_sts         (w_sts),
        .o_power_mod   (o_rsp.power_mod),
        .o_bad_modulus (o_rsp.bad_modulus)
    );

endmodule

>>> hdl/mexp_checker.sv
// port-level checks for modular exponentiation, bound to the top level
`include "modular_exponentiation_assert.svh"

module mexp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [mexp_pkg::DATA_BITS-1:0] i_power_mod,
    input logic                           i_bad_modulus
);
    import mexp_pkg::*;

    // a stalled result word stays offered
    `MEXP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a stalled result word keeps its payload
    `MEXP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_power_mod) && $stable(i_bad_modulus))

    // a rejected modulus always reports a zero power
    `MEXP_ASSERT_SAME(a_bad_zero, i_clk, i_rst_n, i_out_valid && i_bad_modulus, i_power_mod == '0)

    // one request at a time: busy right after taking a word
    `MEXP_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind modular_exponentiation mexp_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_power_mod   (o_rsp.power_mod),
    .i_bad_modulus (o_rsp.bad_modulus)
);

>>> dv/tb_modular_exponentiation.sv
// self-checking testbench for the modular exponentiation block
module tb_modular_exponentiation;
    import mexp_pkg::*;

    localparam int OPERAND_BITS  = 32;
    localparam int IDLE_PERCENT  = 35;
    localparam int STALL_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 50;
    localparam int REPORT_LIMIT  = 10;
    localparam int MIXED_WORDS   = 230;
    localparam int STEADY_WORDS  = 45;

    localparam logic [EXP_BITS-1:0]  EXP_MAX   = {EXP_BITS{1'b1}};
    localparam logic [DATA_BITS-1:0] DATA_MAX  = {DATA_BITS{1'b1}};
    localparam logic [DATA_BITS-1:0] BIG_PRIME = 32'hFFFF_FFFB;

    typedef struct packed {
        logic [DATA_BITS-1:0] power_mod;
        logic                 bad_modulus;
    } t_power_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mexp_req_if req_bus ();
    mexp_rsp_if rsp_bus ();

    t_power_result expected_words[$];
    int            mismatch_count = 0;
    int            quiet_cycles = 0;
    bit            steady_flow;

    modular_exponentiation #(
        .OPERAND_BITS(OPERAND_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    // free-running clock
    always #1 i_clk = ~i_clk;

    // square-and-multiply over the exponent, lsb first, exact 64-bit products
    function automatic t_power_result calc_power_mod(input logic [DATA_BITS-1:0] base,
                                                     input logic [EXP_BITS-1:0]  exponent,
                                                     input logic [DATA_BITS-1:0] modulus);
        logic [63:0]   opnd_mask;
        logic [63:0]   m;
        logic [63:0]   acc;
        logic [63:0]   sq;
        t_power_result res;
        int            i;
        opnd_mask       = (64'd1 << OPERAND_BITS) - 64'd1;
        m               = {32'd0, modulus} & opnd_mask;
        res.power_mod   = '0;
        res.bad_modulus = 1'b0;
        if (m == 64'd0) begin
            res.bad_modulus = 1'b1;
            return res;
        end
        acc = 64'd1 % m;
        sq  = ({32'd0, base} & opnd_mask) % m;
        for (i = 0; i < EXP_BITS; i++) begin
            if (exponent[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        res.power_mod = acc[DATA_BITS-1:0];
        return res;
    endfunction

    // drive one request word, return at the edge that takes it
    task automatic send_request(input logic [DATA_BITS-1:0] base,
                                input logic [EXP_BITS-1:0]  exponent,
                                input logic [DATA_BITS-1:0] modulus);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.base     <= base;
        req_bus.exponent <= exponent;
        req_bus.modulus  <= modulus;
        do @(posedge i_clk); while (!req_bus.ready);
        expected_words.push_back(calc_power_mod(base, exponent, modulus));
    endtask

    // operand spread over full range, small values, top of range and powers of two
    function automatic logic [DATA_BITS-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return DATA_BITS'($urandom_range(0, 255));
            1:       return DATA_MAX - DATA_BITS'($urandom_range(0, 255));
            2:       return DATA_BITS'(1) << $urandom_range(0, DATA_BITS - 1);
            default: return DATA_BITS'($urandom());
        endcase
    endfunction

    // mostly short exponents, some mid-size, a few full width
    function automatic logic [EXP_BITS-1:0] rand_exponent();
        logic [EXP_BITS-1:0] raw;
        int                  width;
        int                  pick;
        raw  = EXP_BITS'({$urandom(), $urandom()});
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            width = $urandom_range(0, 12);
        end else if (pick < 85) begin
            width = $urandom_range(13, 32);
        end else begin
            width = EXP_BITS;
        end
        return raw & ((EXP_BITS'(1) << width) - EXP_BITS'(1));
    endfunction

    // modulus with zero and one now and then
    function automatic logic [DATA_BITS-1:0] rand_modulus();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            return '0;
        end else if (pick < 8) begin
            return DATA_BITS'(1);
        end
        return rand_operand();
    endfunction

    // zero modulus flags an error whatever the other fields
    task automatic test_bad_modulus();
        send_request(32'd5, 63'd10, '0);
        send_request(DATA_MAX, EXP_MAX, '0);
        send_request('0, '0, '0);
    endtask

    // modulus one always reduces to zero
    task automatic test_unit_modulus();
        send_request(32'd7, '0, 32'd1);
        send_request(DATA_MAX, EXP_MAX, 32'd1);
        send_request('0, 63'd3, 32'd1);
    endtask

    // exponent zero gives one reduced by the modulus
    task automatic test_zero_exponent();
        send_request('0, '0, 32'd13);
        send_request(32'd123, '0, DATA_MAX);
        send_request(DATA_MAX, '0, 32'd2);
    endtask

    // field extremes, base above modulus, single top exponent bit
    task automatic test_operand_extremes();
        send_request('0, 63'd5, 32'd97);
        send_request(DATA_MAX, 63'd3, 32'd1000);
        send_request(DATA_MAX, EXP_MAX, DATA_MAX);
        send_request(DATA_MAX - 32'd1, EXP_MAX, DATA_MAX);
        send_request(32'd2, 63'(BIG_PRIME - 32'd1), BIG_PRIME);
        send_request(32'd3, EXP_BITS'(1) << (EXP_BITS - 1), BIG_PRIME);
        send_request(32'd2, 63'd10, 32'd1025);
        send_request(32'd1, EXP_MAX, 32'd2);
        send_request(32'h8000_0001, 63'h5555_5555_5555_5555, 32'h8000_0000);
    endtask

    // random words with random gaps on both sides
    task automatic test_random_mixed();
        int n;
        for (n = 0; n < MIXED_WORDS; n++) begin
            send_request(rand_operand(), rand_exponent(), rand_modulus());
        end
    endtask

    // one long stretch with both sides always ready
    task automatic test_steady_flow();
        int n;
        steady_flow = 1'b1;
        for (n = 0; n < STEADY_WORDS; n++) begin
            send_request(rand_operand(), rand_exponent(), rand_modulus());
        end
        steady_flow = 1'b0;
    endtask

    // result receiver with random back-pressure
    always @(negedge i_clk) begin
        rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // compare each result word against the oldest expectation
    always @(posedge i_clk) begin
        t_power_result want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected result word: power_mod %0h bad_modulus %0b",
                             rsp_bus.power_mod, rsp_bus.bad_modulus);
                end
            end else begin
                want = expected_words.pop_front();
                if (rsp_bus.power_mod !== want.power_mod ||
                    rsp_bus.bad_modulus !== want.bad_modulus) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("mismatch: power_mod exp %0h got %0h, bad_modulus exp %0b got %0b",
                                 want.power_mod, rsp_bus.power_mod,
                                 want.bad_modulus, rsp_bus.bad_modulus);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset, run the tests in turn, drain and report
    initial begin
        i_rst_n          = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.base     = '0;
        req_bus.exponent = '0;
        req_bus.modulus  = '0;
        steady_flow      = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_bad_modulus();
        test_unit_modulus();
        test_zero_exponent();
        test_operand_extremes();
        test_random_mixed();
        test_steady_flow();

        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
